>>> hdl/srq_pkg.sv
// ----------------------------------------------------------------------------
// srq_pkg
// Shared types and constants for the sequence reassembly queue.
// ----------------------------------------------------------------------------
package srq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SEQ_W       = 64;
    localparam int LEN_W       = 16;
    localparam int HELD_W      = 24;

    localparam logic [0:0] REG_INITIAL_NEXT_SEQ = 1'b0;

    localparam logic KIND_DELIVERED = 1'b0;
    localparam logic KIND_STATUS    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIM,
        ST_PREV,
        ST_INSERT,
        ST_DELIVER,
        ST_OUT,
        ST_STATUS
    } state_t;

    // one table entry
    typedef struct packed {
        logic             valid;
        logic [SEQ_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             fin;
    } entry_t;

    // command broadcast from the sequencer to every cell
    typedef struct packed {
        logic             trim_en;    // trim the first entry that overlaps end
        logic             insert_en;  // shift up from position and write new entry
        logic             pop_en;     // shift the whole chain down by one
        logic [SEQ_W-1:0] seg_start;
        logic [SEQ_W-1:0] seg_end;
        logic [LEN_W-1:0] seg_len;
        logic             seg_fin;
    } cell_cmd_t;

    // true when the modular difference is strictly positive
    function automatic logic diff_pos(input logic [SEQ_W-1:0] d);
        return (d != '0) && !d[SEQ_W-1];
    endfunction

endpackage

>>> hdl/sequence_reassembly_queue.sv
// ----------------------------------------------------------------------------
// sequence_reassembly_queue
// Out-of-order segment descriptor table with in-order delivery.
// ----------------------------------------------------------------------------
// Usage: segment descriptors enter on the s_ channel (valid/ready). Each one
// is trimmed against the next expected number and the preceding held entry,
// covered held entries are removed one per cycle, the segment is inserted
// into a chain of QUEUE_DEPTH cells, and then each in-order head is popped
// and sent on the m_ channel as a delivered descriptor. A status transaction
// with m_last high always closes the results of one input.
// Steps: trim against next_seq in ST_TRIM, trim against the preceding entry
// in ST_PREV, one removal per covered entry and then the insert in
// ST_INSERT, then ST_DELIVER and ST_OUT for each delivered head, ST_DELIVER
// once more to find no further head, and ST_STATUS for the status item.
// One item is in work at a time; the chain shifts one step a cycle.
// Reset clears all valid bits, next_seq, held_bytes and the config
// register. A stalled receiver holds m_ data steady; the sequencer waits in
// the output state and accepts no new input until the status item leaves.
// The APB port writes initial_next_seq at address 0 and reloads next_seq.
// ----------------------------------------------------------------------------
module sequence_reassembly_queue
    import srq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // apb
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [0:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [SEQ_W-1:0]  s_seg_seq,
    input  logic [LEN_W-1:0]  s_seg_len,
    input  logic              s_seg_final,
    input  logic              s_rx_closed,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_kind,
    output logic [SEQ_W-1:0]  m_out_seq,
    output logic [LEN_W-1:0]  m_out_len,
    output logic              m_out_final,
    output logic              m_out_discarded,
    output logic [SEQ_W-1:0]  m_next_expected,
    output logic [HELD_W-1:0] m_queued_bytes,
    output logic              m_fin_returned,
    output logic              m_ack_now,
    output logic              m_overflow,
    output logic              m_last
);

    state_t            state_reg, state_next;
    logic [SEQ_W-1:0]  init_reg;
    logic [SEQ_W-1:0]  next_seq_reg;
    logic [HELD_W-1:0] held_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              fin_reg, closed_reg, drop_reg, ovf_reg;
    logic              fin_ret_reg, ack_reg;
    logic [QUEUE_DEPTH-1:0] front_reg;

    logic              cfg_wr;
    cell_cmd_t         cmd;
    entry_t            ent      [QUEUE_DEPTH];
    entry_t            prv      [QUEUE_DEPTH];
    entry_t            nxt      [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] after_v, cov_v, ovl_v, valid_v;
    logic [QUEUE_DEPTH-1:0] ins_here_v, ins_shift_v, trim_v, clr_v, clr_sh_v;
    logic [QUEUE_DEPTH-1:0] front_v, rm_v, p_onehot;
    logic [IDX_W-1:0]  count;
    logic              any_rm, head_match;
    logic              trim_ok, trim_drop;
    logic [SEQ_W-1:0]  trim_seq, d0, dp, prev_end;
    logic [LEN_W-1:0]  trim_len;
    logic [LEN_W-1:0]  ovl_amt;
    logic [SEQ_W-1:0]  seq_t;
    logic [LEN_W-1:0]  len_t;
    logic              has_prev;
    entry_t            prev_e;
    entry_t            empty_e;

    // apb
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_INITIAL_NEXT_SEQ);
    assign prdata = (paddr == REG_INITIAL_NEXT_SEQ) ? init_reg : '0;

    always_comb begin
        empty_e       = '0;
        empty_e.valid = 1'b0;
    end

    // chain status
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            valid_v[i] = ent[i].valid;
        end
        count = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            count = count + IDX_W'(valid_v[i]);
        end
        // entries at or before segment start, up to the first one after it
        front_v[0] = valid_v[0] && !after_v[0];
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            front_v[i] = valid_v[i] && !after_v[i] && front_v[i-1];
        end
        // insert position latched before the preceding-entry trim
        p_onehot[0] = !front_reg[0];
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            p_onehot[i] = !front_reg[i] && front_reg[i-1];
        end
        rm_v    = p_onehot & valid_v & cov_v;
        any_rm  = |rm_v;
    end

    // trim against next_seq; the trim against the last front entry follows in ST_PREV
    always_comb begin
        d0       = next_seq_reg - seq_reg;
        seq_t    = seq_reg;
        len_t    = len_reg;
        trim_drop = 1'b0;
        if (diff_pos(d0)) begin
            if (d0 < {{(SEQ_W-LEN_W){1'b0}}, len_reg}) begin
                seq_t = seq_reg + d0;
                len_t = len_reg - d0[LEN_W-1:0];
            end else begin
                trim_drop = 1'b1;
            end
        end
        trim_seq = seq_t;
        trim_len = len_t;
        trim_ok  = !trim_drop;
    end

    // preceding entry, after the first trim has been registered
    always_comb begin
        prev_e   = empty_e;
        has_prev = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (front_v[i]) begin
                prev_e   = ent[i];
                has_prev = 1'b1;
            end
        end
        prev_end = prev_e.start + {{(SEQ_W-LEN_W){1'b0}}, prev_e.len};
        dp       = prev_end - seq_reg;
    end

    // command to the cells
    always_comb begin
        cmd           = '0;
        cmd.seg_start = seq_reg;
        cmd.seg_end   = seq_reg + {{(SEQ_W-LEN_W){1'b0}}, len_reg};
        cmd.seg_len   = len_reg;
        cmd.seg_fin   = fin_reg;
        cmd.pop_en    = (state_reg == ST_DELIVER) && head_match;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            ins_here_v[i]  = 1'b0;
            ins_shift_v[i] = 1'b0;
            trim_v[i]      = 1'b0;
            clr_v[i]       = 1'b0;
            clr_sh_v[i]    = 1'b0;
        end
        if (state_reg == ST_INSERT && !drop_reg) begin
            if (any_rm) begin
                // remove the covered entry at the insert position, upper cells move down
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    clr_v[i] = rm_v[i];
                end
                for (int i = 1; i < QUEUE_DEPTH; i++) begin
                    clr_sh_v[i] = clr_v[i-1] || clr_sh_v[i-1];
                end
            end else if (count != IDX_W'(QUEUE_DEPTH)) begin
                cmd.insert_en = 1'b1;
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    ins_here_v[i] = p_onehot[i];
                end
                for (int i = 1; i < QUEUE_DEPTH; i++) begin
                    ins_shift_v[i] = valid_v[i-1] && !front_reg[i-1];
                end
                // the following entry is trimmed as it shifts up, in the same step
                for (int i = 1; i < QUEUE_DEPTH; i++) begin
                    if (ins_here_v[i-1] && ovl_v[i-1] && valid_v[i-1]) begin
                        trim_v[i] = 1'b1;
                    end
                end
            end
        end
        // bytes cut from the following entry
        ovl_amt = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (p_onehot[i] && valid_v[i] && ovl_v[i]) begin
                ovl_amt = LEN_W'(cmd.seg_end - ent[i].start);
            end
        end
    end

    // cell chain wiring
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            prv[i] = (i == 0) ? empty_e : ent[(i == 0) ? 0 : i - 1];
            if (trim_v[i] && i > 0) begin
                prv[i].start = cmd.seg_end;
                prv[i].len   = ent[i-1].len -
                               LEN_W'(cmd.seg_end - ent[i-1].start);
            end
            nxt[i] = (i == QUEUE_DEPTH - 1) ? empty_e
                                           : ent[(i == QUEUE_DEPTH - 1) ? i : i + 1];
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        srq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .clr_en     (clr_v[g]),
            .clr_shift  (clr_sh_v[g]),
            .ins_here   (ins_here_v[g]),
            .ins_shift  (ins_shift_v[g]),
            .trim_here  (1'b0),
            .prev_entry (prv[g]),
            .next_entry (nxt[g]),
            .entry      (ent[g]),
            .after_seg  (after_v[g]),
            .covered    (cov_v[g]),
            .overlapped (ovl_v[g])
        );
    end

    assign head_match = ent[0].valid && (ent[0].start == next_seq_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_TRIM;
            ST_TRIM:    state_next = ST_PREV;
            ST_PREV:    state_next = ST_INSERT;
            ST_INSERT:  if (drop_reg || !any_rm) state_next = ST_DELIVER;
            ST_DELIVER: state_next = head_match ? ST_OUT : ST_STATUS;
            ST_OUT:     if (m_ready) state_next = ST_DELIVER;
            ST_STATUS:  if (m_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_OUT) || (state_reg == ST_STATUS);
        m_kind  = (state_reg == ST_STATUS) ? KIND_STATUS : KIND_DELIVERED;
        m_last  = (state_reg == ST_STATUS);
        m_next_expected = (state_reg == ST_STATUS) ? next_seq_reg : '0;
        m_queued_bytes  = (state_reg == ST_STATUS) ? held_reg : '0;
        m_fin_returned  = (state_reg == ST_STATUS) && fin_ret_reg;
        m_ack_now       = (state_reg == ST_STATUS) && ack_reg;
        m_overflow      = (state_reg == ST_STATUS) && ovf_reg;
    end

    // delivered descriptor holding register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DELIVER && head_match) begin
            m_out_seq       <= ent[0].start;
            m_out_len       <= ent[0].len;
            m_out_final     <= ent[0].fin;
            m_out_discarded <= closed_reg;
        end else if (state_reg == ST_DELIVER) begin
            m_out_seq       <= '0;
            m_out_len       <= '0;
            m_out_final     <= 1'b0;
            m_out_discarded <= 1'b0;
        end
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            init_reg     <= '0;
            next_seq_reg <= '0;
            held_reg     <= '0;
            drop_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
            fin_ret_reg  <= 1'b0;
            ack_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                init_reg     <= pwdata;
                next_seq_reg <= pwdata;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        seq_reg     <= s_seg_seq;
                        len_reg     <= s_seg_len;
                        fin_reg     <= s_seg_final;
                        closed_reg  <= s_rx_closed;
                        fin_ret_reg <= 1'b0;
                        ack_reg     <= 1'b0;
                        ovf_reg     <= 1'b0;
                        drop_reg    <= 1'b0;
                    end
                end
                ST_TRIM: begin
                    // next_seq trim is done here, prev trim in the next state
                    seq_reg  <= trim_seq;
                    len_reg  <= trim_len;
                    drop_reg <= !trim_ok;
                end
                ST_PREV: begin
                    // insert position is fixed before the segment start moves
                    front_reg <= front_v;
                    if (!drop_reg && has_prev && diff_pos(dp)) begin
                        if (dp >= {{(SEQ_W-LEN_W){1'b0}}, len_reg}) begin
                            drop_reg <= 1'b1;
                        end else begin
                            seq_reg <= seq_reg + dp;
                            len_reg <= len_reg - dp[LEN_W-1:0];
                        end
                    end
                end
                ST_INSERT: begin
                    if (!drop_reg) begin
                        if (any_rm) begin
                            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                                if (clr_v[i]) begin
                                    held_reg <= held_reg - HELD_W'(ent[i].len);
                                end
                            end
                        end else if (count == IDX_W'(QUEUE_DEPTH)) begin
                            ovf_reg  <= 1'b1;
                            drop_reg <= 1'b1;
                        end else begin
                            held_reg <= held_reg + HELD_W'(len_reg) - HELD_W'(ovl_amt);
                        end
                    end
                end
                ST_DELIVER: begin
                    if (head_match) begin
                        next_seq_reg <= next_seq_reg + {{(SEQ_W-LEN_W){1'b0}}, ent[0].len};
                        held_reg     <= held_reg - HELD_W'(ent[0].len);
                        fin_ret_reg  <= ent[0].fin;
                        if (!closed_reg) ack_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> hdl/srq_cell.sv
// ----------------------------------------------------------------------------
// srq_cell
// One table slot: holds an entry, compares it to the segment and shifts
// with its neighbors on insert, remove and pop.
// ----------------------------------------------------------------------------
module srq_cell
    import srq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_cmd_t cmd,
    input  logic      clr_en,      // this cell's entry is covered and removed
    input  logic      clr_shift,   // a lower cell was removed: take upper neighbor
    input  logic      ins_here,    // new entry lands here
    input  logic      ins_shift,   // take lower neighbor (insert shifts up)
    input  logic      trim_here,
    input  entry_t    prev_entry,
    input  entry_t    next_entry,
    output entry_t    entry,
    output logic      after_seg,   // entry start is after segment start
    output logic      covered,     // segment end is at or past the entry end
    output logic      overlapped   // segment end falls inside entry
);

    entry_t           entry_reg;
    entry_t           entry_next;
    logic [SEQ_W-1:0] d_end;

    // compare against the segment
    always_comb begin
        d_end      = cmd.seg_end - entry_reg.start;
        after_seg  = diff_pos(entry_reg.start - cmd.seg_start);
        covered    = diff_pos(d_end) && (d_end >= {{(SEQ_W-LEN_W){1'b0}}, entry_reg.len});
        overlapped = diff_pos(d_end) && (d_end <  {{(SEQ_W-LEN_W){1'b0}}, entry_reg.len});
    end

    // next entry
    always_comb begin
        entry_next = entry_reg;
        if (cmd.pop_en || clr_shift || clr_en) begin
            entry_next = next_entry;
        end else if (ins_here) begin
            entry_next.valid = 1'b1;
            entry_next.start = cmd.seg_start;
            entry_next.len   = cmd.seg_len;
            entry_next.fin   = cmd.seg_fin;
        end else if (ins_shift) begin
            entry_next = prev_entry;
        end else if (trim_here) begin
            entry_next.start = cmd.seg_end;
            entry_next.len   = entry_reg.len - d_end[LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

>>> hdl/srq_checker.sv
// ----------------------------------------------------------------------------
// srq_checker
// Port-level checks on the reassembly queue, bound to the top level.
// ----------------------------------------------------------------------------
module srq_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_kind,
    input logic m_last
);

    // the status transaction and only it carries last
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == m_kind))
        else $error("last does not match kind");

    // no input taken while results are pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted during output");

    // one transaction in work at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready right after an accepted transaction");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_kind))
        else $error("result dropped under stall");

    // after status leaves the block is ready again
    a_ready_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> s_ready)
        else $error("not ready after status");

endmodule

bind sequence_reassembly_queue srq_checker u_srq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_kind  (m_kind),
    .m_last  (m_last)
);

>>> dv/sequence_reassembly_queue_test.sv
// ----------------------------------------------------------------------------
// sequence_reassembly_queue_test
// Self-checking testbench for the segment reassembly queue: directed and
// random segment descriptors, a built-in predictor of the held table and of
// in-order delivery, and a field-by-field scoreboard on the result channel.
// ----------------------------------------------------------------------------
module sequence_reassembly_queue_test;
    import srq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic             fin;
        logic             closed;
    } segment_t;

    typedef struct {
        logic              kind;
        logic [SEQ_W-1:0]  out_seq;
        logic [LEN_W-1:0]  out_len;
        logic              out_final;
        logic              out_discarded;
        logic [SEQ_W-1:0]  next_expected;
        logic [HELD_W-1:0] queued_bytes;
        logic              fin_returned;
        logic              ack_now;
        logic              overflow;
        logic              last;
    } result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [0:0]        paddr = REG_INITIAL_NEXT_SEQ;
    logic [63:0]       pwdata = '0;
    logic [63:0]       prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [SEQ_W-1:0]  s_seg_seq = '0;
    logic [LEN_W-1:0]  s_seg_len = '0;
    logic              s_seg_final = 1'b0;
    logic              s_rx_closed = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_kind;
    logic [SEQ_W-1:0]  m_out_seq;
    logic [LEN_W-1:0]  m_out_len;
    logic              m_out_final;
    logic              m_out_discarded;
    logic [SEQ_W-1:0]  m_next_expected;
    logic [HELD_W-1:0] m_queued_bytes;
    logic              m_fin_returned;
    logic              m_ack_now;
    logic              m_overflow;
    logic              m_last;

    sequence_reassembly_queue i_dut (.*);

    // predictor state: the held table, next expected number, byte count
    logic [SEQ_W-1:0]  tbl_start [QUEUE_DEPTH];
    logic [LEN_W-1:0]  tbl_len   [QUEUE_DEPTH];
    logic              tbl_fin   [QUEUE_DEPTH];
    int                tbl_count = 0;
    logic [SEQ_W-1:0]  next_seq_model = '0;
    logic [HELD_W-1:0] held_model = '0;

    segment_t pending_segs[$];
    result_t  expected_results[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  seg_taken = 0;
    int  mismatches = 0;
    int  unexpected = 0;
    int  segs_sent = 0;
    int  results_seen = 0;
    int  deliveries_seen = 0;
    int  overflows_seen = 0;
    logic [SEQ_W-1:0] gen_base = '0;

    // a is after b when the modular difference is nonzero and below 2^63
    function automatic bit is_after(input logic [SEQ_W-1:0] d);
        return (d != '0) && !d[SEQ_W-1];
    endfunction

    function automatic void drop_entry(input int idx);
        for (int k = idx; k + 1 < tbl_count; k++) begin
            tbl_start[k] = tbl_start[k+1];
            tbl_len[k]   = tbl_len[k+1];
            tbl_fin[k]   = tbl_fin[k+1];
        end
        if (tbl_count > 0) tbl_count--;
    endfunction

    // trim, insert and drain one segment; queue the results it causes
    function automatic void reassemble_segment(input segment_t sg);
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] len;
        logic [SEQ_W-1:0] d;
        logic [SEQ_W-1:0] seg_end;
        bit      drop;
        bit      ovf;
        int      p;
        int      covered;
        logic    fin_ret;
        logic    ack;
        result_t r;
        seq = sg.seq;
        len = 64'(sg.len);
        drop = 0;
        ovf = 0;
        p = 0;
        covered = 0;
        fin_ret = 0;
        ack = 0;
        // trim against the next expected number
        d = next_seq_model - seq;
        if (is_after(d)) begin
            if (d < len) begin
                seq += d;
                len -= d;
            end else drop = 1;
        end
        // trim against the preceding held entry
        if (!drop) begin
            while (p < tbl_count && !is_after(tbl_start[p] - seq)) p++;
            if (p > 0) begin
                d = tbl_start[p-1] + 64'(tbl_len[p-1]) - seq;
                if (is_after(d)) begin
                    if (d >= len) drop = 1;
                    else begin
                        seq += d;
                        len -= d;
                    end
                end
            end
        end
        // remove covered entries, trim the next one, insert
        if (!drop) begin
            seg_end = seq + len;
            for (int k = p; k < tbl_count; k++) begin
                d = seg_end - tbl_start[k];
                if (!is_after(d) || d < 64'(tbl_len[k])) break;
                covered++;
            end
            if (tbl_count - covered + 1 > QUEUE_DEPTH) begin
                ovf = 1;
            end else begin
                for (int k = 0; k < covered; k++) begin
                    held_model -= HELD_W'(tbl_len[p]);
                    drop_entry(p);
                end
                if (p < tbl_count) begin
                    d = seg_end - tbl_start[p];
                    if (is_after(d) && d < 64'(tbl_len[p])) begin
                        tbl_start[p] += d;
                        tbl_len[p]   -= LEN_W'(d);
                        held_model   -= HELD_W'(d);
                    end
                end
                for (int k = tbl_count; k > p; k--) begin
                    tbl_start[k] = tbl_start[k-1];
                    tbl_len[k]   = tbl_len[k-1];
                    tbl_fin[k]   = tbl_fin[k-1];
                end
                tbl_start[p] = seq;
                tbl_len[p]   = LEN_W'(len);
                tbl_fin[p]   = sg.fin;
                tbl_count++;
                held_model += HELD_W'(len);
            end
        end
        // deliver every head that starts at the next expected number
        while (tbl_count > 0 && tbl_start[0] == next_seq_model) begin
            r = '{default: '0};
            r.kind          = KIND_DELIVERED;
            r.out_seq       = tbl_start[0];
            r.out_len       = tbl_len[0];
            r.out_final     = tbl_fin[0];
            r.out_discarded = sg.closed;
            next_seq_model += 64'(tbl_len[0]);
            held_model     -= HELD_W'(tbl_len[0]);
            fin_ret = tbl_fin[0];
            if (!sg.closed) ack = 1;
            drop_entry(0);
            expected_results.push_back(r);
        end
        r = '{default: '0};
        r.kind          = KIND_STATUS;
        r.next_expected = next_seq_model;
        r.queued_bytes  = held_model;
        r.fin_returned  = fin_ret;
        r.ack_now       = ack;
        r.overflow      = ovf;
        r.last          = 1'b1;
        expected_results.push_back(r);
    endfunction

    // clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || seg_taken) begin
            seg_taken = 0;
            if (pending_segs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                segment_t sg;
                sg = pending_segs.pop_front();
                s_seg_seq   <= sg.seq;
                s_seg_len   <= sg.len;
                s_seg_final <= sg.fin;
                s_rx_closed <= sg.closed;
                s_valid     <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: predict on accepted segments, check accepted results
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            segment_t sg;
            sg.seq    = s_seg_seq;
            sg.len    = s_seg_len;
            sg.fin    = s_seg_final;
            sg.closed = s_rx_closed;
            reassemble_segment(sg);
            seg_taken = 1;
            segs_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_kind == KIND_DELIVERED) deliveries_seen++;
            if (m_overflow) overflows_seen++;
            if (expected_results.size() == 0) begin
                unexpected++;
                if (unexpected + mismatches <= 10)
                    $display("unexpected result transaction at %0t", $realtime);
            end else begin
                result_t e;
                e = expected_results.pop_front();
                if (m_kind !== e.kind || m_out_seq !== e.out_seq || m_out_len !== e.out_len
                    || m_out_final !== e.out_final || m_out_discarded !== e.out_discarded
                    || m_next_expected !== e.next_expected
                    || m_queued_bytes !== e.queued_bytes
                    || m_fin_returned !== e.fin_returned || m_ack_now !== e.ack_now
                    || m_overflow !== e.overflow || m_last !== e.last) begin
                    mismatches++;
                    if (unexpected + mismatches <= 10) begin
                        $display("mismatch at %0t: exp kind %0d seq %h len %h fin %0d disc %0d",
                                 $realtime, e.kind, e.out_seq, e.out_len, e.out_final,
                                 e.out_discarded);
                        $display("    nexp %h held %h finret %0d ack %0d ovf %0d last %0d",
                                 e.next_expected, e.queued_bytes, e.fin_returned,
                                 e.ack_now, e.overflow, e.last);
                        $display("  got kind %0d seq %h len %h fin %0d disc %0d",
                                 m_kind, m_out_seq, m_out_len, m_out_final, m_out_discarded);
                        $display("    nexp %h held %h finret %0d ack %0d ovf %0d last %0d",
                                 m_next_expected, m_queued_bytes, m_fin_returned,
                                 m_ack_now, m_overflow, m_last);
                    end
                end
            end
        end
    end

    // run limit
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic add_seg(input logic [SEQ_W-1:0] seq, input int len,
                           input bit fin = 0, input bit closed = 0);
        segment_t sg;
        sg.seq    = seq;
        sg.len    = LEN_W'(len);
        sg.fin    = fin;
        sg.closed = closed;
        pending_segs.push_back(sg);
    endtask

    // wait until every segment is in and every result is out
    task automatic drain();
        while (pending_segs.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (2 * QUEUE_DEPTH + 12) @(posedge aclk);
    endtask

    task automatic write_next_seq(input logic [63:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_INITIAL_NEXT_SEQ;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        next_seq_model = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        gen_base = value;
    endtask

    // a shuffled, partly overlapping run of segments ahead of the base, plus noise
    task automatic add_random_burst(inout int budget);
        segment_t burst[$];
        segment_t sg;
        segment_t tmp;
        int k;
        int j;
        logic [SEQ_W-1:0] pos;
        k = $urandom_range(2, 6);
        pos = gen_base;
        for (int i = 0; i < k; i++) begin
            sg.seq    = pos;
            sg.len    = ($urandom_range(19) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(64));
            sg.fin    = ($urandom_range(9) == 0);
            sg.closed = ($urandom_range(6) == 0);
            pos += 64'(sg.len);
            if ($urandom_range(3) == 0) begin
                j = $urandom_range(8);
                sg.seq -= 64'(j);
                sg.len += LEN_W'(j + $urandom_range(8));
            end
            burst.push_back(sg);
        end
        gen_base = pos;
        if ($urandom_range(4) == 0) begin
            sg.seq    = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                                 : gen_base - 64'($urandom_range(600));
            sg.len    = LEN_W'($urandom_range(700));
            sg.fin    = 1'($urandom_range(1));
            sg.closed = 1'($urandom_range(1));
            burst.push_back(sg);
        end
        for (int i = burst.size() - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = burst[i];
            burst[i] = burst[j];
            burst[j] = tmp;
        end
        foreach (burst[i]) pending_segs.push_back(burst[i]);
        budget -= burst.size();
    endtask

    // stimulus and phases
    initial begin
        logic [SEQ_W-1:0] b;
        int budget;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, starting just below the wrap of the sequence space
        send_idle_pct = 35;
        recv_idle_pct = 86;
        write_next_seq(64'hFFFF_FFFF_FFFF_FF00);
        b = 64'hFFFF_FFFF_FFFF_FF00;
        add_seg(b + 64'h100, 16'h20);            // held out of order
        add_seg(b, 16'h10);                      // in order
        add_seg(b + 64'h10, 0);                  // zero length at head
        add_seg(b - 64'd5, 3);                   // full duplicate before next
        add_seg(b + 64'h0C, 8, 0, 1);            // overlap, closed receiver
        add_seg(b + 64'h104, 4);                 // covered by preceding entry
        add_seg(b + 64'h14, 16'hFFFF, 1);        // max length, fin, across wrap
        add_seg(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1, 1);
        add_seg(64'h0, 0);
        drain();
        b = next_seq_model;
        // seven contiguous held entries, then a fill delivering eight
        for (int i = 0; i < 7; i++) add_seg(b + 64'(1 + 2 * i), 2, i == 6);
        add_seg(b, 1);
        drain();
        b = next_seq_model;
        // fill the table, overflow, then a covering segment
        for (int i = 0; i < QUEUE_DEPTH; i++) add_seg(b + 64'(10 + 10 * i), 1);
        add_seg(b + 64'd200, 5);
        add_seg(b, 10);
        add_seg(b, 200, 1);
        drain();

        budget = 33;
        gen_base = next_seq_model;
        while (budget > 0) add_random_burst(budget);
        drain();

        send_idle_pct = 86;
        recv_idle_pct = 35;
        write_next_seq(64'h0);
        budget = 33;
        while (budget > 0) add_random_burst(budget);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_next_seq(64'hFFFF_FFFF_FFFF_FFFF);
        budget = 33;
        while (budget > 0) add_random_burst(budget);
        drain();

        // reload mid-stream with entries still held
        write_next_seq({$urandom, $urandom});
        budget = 33;
        while (budget > 0) add_random_burst(budget);
        drain();

        $display("%0d segments sent over four next-sequence settings and three idling mixes",
                 segs_sent);
        $display("%0d results checked: %0d deliveries, %0d overflow drops",
                 results_seen, deliveries_seen, overflows_seen);
        if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
